[rtl/fcti_pkg.sv]
// shared widths, codes, default curve and controller/datapath bundles
// for the fan curve table interpolator; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fcti_pkg;

    // table size and derived widths
    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // field widths
    localparam int OPC_W  = 2;
    localparam int TEMP_W = 8;
    localparam int SPD_W  = 7;
    localparam int STAT_W = 2;
    localparam int USED_W = 5;
    localparam int PT_W   = 7;
    localparam int PROD_W = 2 * PT_W;

    // divider bit counter width
    localparam int DIV_CNT_W = $clog2(PROD_W + 1);

    // default curve
    localparam int DEF_POINTS  = 6;
    localparam int RESET_COUNT = (DEF_POINTS < MAX_POINTS) ? DEF_POINTS : MAX_POINTS;

    localparam logic [SPD_W-1:0]  SPEED_CEIL = 7'd100;
    localparam logic [TEMP_W-1:0] TEMP_CEIL  = 8'd100;

    // opcodes
    localparam logic [OPC_W-1:0] OP_QUERY = 2'd0;
    localparam logic [OPC_W-1:0] OP_SET   = 2'd1;
    localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear;
        logic scan_next;
        logic div_start;
        logic fan_min;
        logic fan_cur;
        logic fan_interp;
        logic stat_full;
        logic stat_range;
        logic write_speed;
        logic shift_start;
        logic shift_step;
        logic write_point;
        logic out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic             t_over;
        logic             cnt_zero;
        logic             idx_zero;
        logic             at_end;
        logic             last;
        logic             gt;
        logic             ge;
        logic             eq;
        logic             full;
        logic             at_pos;
        logic             div_done;
    } stat_t;

    function automatic logic [PT_W-1:0] def_temp(input int i);
        logic [PT_W-1:0] v;
        case (i)
            0:       v = 7'd30;
            1:       v = 7'd40;
            2:       v = 7'd50;
            3:       v = 7'd60;
            4:       v = 7'd70;
            5:       v = 7'd80;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [PT_W-1:0] def_speed(input int i);
        logic [PT_W-1:0] v;
        case (i)
            0:       v = 7'd30;
            1:       v = 7'd40;
            2:       v = 7'd55;
            3:       v = 7'd65;
            4:       v = 7'd85;
            5:       v = 7'd100;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/fcti_if.sv]
// valid/ready channel interfaces: item input, result output, config write
// depends on fcti_pkg
`timescale 1ns / 1ps
`default_nettype none

interface fcti_in_if import fcti_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  opcode;
    logic [TEMP_W-1:0] temperature;
    logic [SPD_W-1:0]  speed;

    modport source (output valid, output opcode, output temperature, output speed,
                    input ready);
    modport sink (input valid, input opcode, input temperature, input speed,
                  output ready);
endinterface

interface fcti_out_if import fcti_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SPD_W-1:0]  duty_pct;
    logic [STAT_W-1:0] status;
    logic [USED_W-1:0] points_used;

    modport source (output valid, output duty_pct, output status, output points_used,
                    input ready);
    modport sink (input valid, input duty_pct, input status, input points_used,
                  output ready);
endinterface

interface fcti_cfg_if import fcti_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SPD_W-1:0] min_speed;

    modport source (output valid, output min_speed, input ready);
    modport sink (input valid, input min_speed, output ready);
endinterface

`default_nettype wire

[rtl/fcti_div.sv]
// restoring serial divider, one quotient bit per cycle
// depends on fcti_pkg
`timescale 1ns / 1ps
`default_nettype none

module fcti_div import fcti_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [PT_W-1:0]   divisor,
    output logic              done,
    output logic [PROD_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [PT_W-1:0]      rem_reg;
    logic [PT_W-1:0]      dvs_reg;
    logic [PROD_W-1:0]    quo_reg;

    logic [PT_W:0]        trial;
    logic                 fits;

    // trial subtract of the shifted remainder
    assign trial = {rem_reg, quo_reg[PROD_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(PROD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_reg <= PT_W'(trial - {1'b0, dvs_reg});
            else
                rem_reg <= trial[PT_W-1:0];
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/fcti_dp.sv]
// datapath: point table, item and result registers, interpolation math
// depends on fcti_pkg and fcti_div
`timescale 1ns / 1ps
`default_nettype none

module fcti_dp import fcti_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             st,
    input  logic [OPC_W-1:0]  in_opcode,
    input  logic [TEMP_W-1:0] in_temperature,
    input  logic [SPD_W-1:0]  in_speed,
    input  logic              cfg_we,
    input  logic [SPD_W-1:0]  cfg_min_speed,
    output logic [SPD_W-1:0]  out_duty_pct,
    output logic [STAT_W-1:0] out_status,
    output logic [USED_W-1:0] out_points_used
);

    logic [PT_W-1:0]   temps_reg  [MAX_POINTS];
    logic [PT_W-1:0]   speeds_reg [MAX_POINTS];
    logic [CNT_W-1:0]  count_reg;
    logic [SPD_W-1:0]  min_speed_reg;

    logic [OPC_W-1:0]  op_reg;
    logic [TEMP_W-1:0] t_reg;
    logic [SPD_W-1:0]  s_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [PT_W-1:0]   prev_temp_reg;
    logic [PT_W-1:0]   prev_speed_reg;
    logic [PT_W-1:0]   lo_speed_reg;
    logic              neg_reg;

    logic [SPD_W-1:0]  fan_reg;
    logic [STAT_W-1:0] status_reg;
    logic [SPD_W-1:0]  out_fan_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [USED_W-1:0] out_used_reg;

    logic [IDX_W-1:0]  idx_lo;
    logic [CNT_W-1:0]  idx_m1;
    logic [PT_W-1:0]   cur_temp;
    logic [PT_W-1:0]   cur_speed;
    logic [PT_W:0]     ds;
    logic [PT_W-1:0]   ds_abs;
    logic [PT_W-1:0]   off;
    logic [PT_W-1:0]   dt;
    logic [PROD_W-1:0] prod;
    logic              div_done;
    logic [PROD_W-1:0] quotient;
    logic signed [PROD_W+1:0] interp;
    logic [SPD_W-1:0]  interp_sat;
    logic [SPD_W-1:0]  min_sat;

    // current table entry
    assign idx_lo    = idx_reg[IDX_W-1:0];
    assign idx_m1    = idx_reg - 1'b1;
    assign cur_temp  = temps_reg[idx_lo];
    assign cur_speed = speeds_reg[idx_lo];

    // segment terms between previous and current entry
    assign ds     = {1'b0, cur_speed} - {1'b0, prev_speed_reg};
    assign ds_abs = ds[PT_W] ? PT_W'(-ds) : ds[PT_W-1:0];
    assign off    = t_reg[PT_W-1:0] - prev_temp_reg;
    assign dt     = cur_temp - prev_temp_reg;
    assign prod   = PROD_W'(off) * PROD_W'(ds_abs);

    fcti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod),
        .divisor  (dt),
        .done     (div_done),
        .quotient (quotient)
    );

    // apply sign of the slope and clamp to 0..100
    assign interp = neg_reg
        ? $signed({{(PROD_W-PT_W+2){1'b0}}, lo_speed_reg}) - $signed({2'b00, quotient})
        : $signed({{(PROD_W-PT_W+2){1'b0}}, lo_speed_reg}) + $signed({2'b00, quotient});
    always_comb
    begin
        if (interp < 0)
            interp_sat = '0;
        else if (interp > $signed((PROD_W+2)'(SPEED_CEIL)))
            interp_sat = SPEED_CEIL;
        else
            interp_sat = interp[SPD_W-1:0];
    end

    assign min_sat = (min_speed_reg > SPEED_CEIL) ? SPEED_CEIL : min_speed_reg;

    // status to the controller
    always_comb
    begin
        st.opcode   = op_reg;
        st.t_over   = (t_reg > TEMP_CEIL);
        st.cnt_zero = (count_reg == '0);
        st.idx_zero = (idx_reg == '0);
        st.at_end   = (idx_reg == count_reg);
        st.last     = (idx_reg == count_reg - 1'b1);
        st.gt       = ({1'b0, cur_temp} > t_reg);
        st.ge       = ({1'b0, cur_temp} >= t_reg);
        st.eq       = ({1'b0, cur_temp} == t_reg);
        st.full     = (count_reg >= CNT_W'(MAX_POINTS));
        st.at_pos   = (idx_reg == pos_reg);
        st.div_done = div_done;
    end

    // point table, count and min speed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                temps_reg[i]  <= def_temp(i);
                speeds_reg[i] <= def_speed(i);
            end
            count_reg     <= CNT_W'(RESET_COUNT);
            min_speed_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                min_speed_reg <= cfg_min_speed;
            if (cmd.clear)
                count_reg <= '0;
            if (cmd.write_speed)
                speeds_reg[idx_lo] <= s_reg;
            if (cmd.shift_step)
            begin
                temps_reg[idx_lo]  <= temps_reg[idx_m1[IDX_W-1:0]];
                speeds_reg[idx_lo] <= speeds_reg[idx_m1[IDX_W-1:0]];
            end
            if (cmd.write_point)
            begin
                temps_reg[idx_lo]  <= t_reg[PT_W-1:0];
                speeds_reg[idx_lo] <= s_reg;
                count_reg          <= count_reg + 1'b1;
            end
        end
    end

    // item, walk and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_opcode;
            t_reg      <= in_temperature;
            s_reg      <= (in_speed > SPEED_CEIL) ? SPEED_CEIL : in_speed;
            idx_reg    <= '0;
            fan_reg    <= '0;
            status_reg <= ST_OK;
        end
        if (cmd.scan_next)
        begin
            idx_reg        <= idx_reg + 1'b1;
            prev_temp_reg  <= cur_temp;
            prev_speed_reg <= cur_speed;
        end
        if (cmd.shift_start)
        begin
            pos_reg <= idx_reg;
            idx_reg <= count_reg;
        end
        if (cmd.shift_step)
            idx_reg <= idx_m1;
        if (cmd.div_start)
        begin
            lo_speed_reg <= prev_speed_reg;
            neg_reg      <= ds[PT_W];
        end
        if (cmd.fan_min)
            fan_reg <= min_sat;
        if (cmd.fan_cur)
            fan_reg <= cur_speed;
        if (cmd.fan_interp)
            fan_reg <= interp_sat;
        if (cmd.stat_full)
            status_reg <= ST_FULL;
        if (cmd.stat_range)
            status_reg <= ST_RANGE;
        if (cmd.out_load)
        begin
            out_fan_reg    <= fan_reg;
            out_status_reg <= status_reg;
            out_used_reg   <= USED_W'(count_reg);
        end
    end

    assign out_duty_pct    = out_fan_reg;
    assign out_status      = out_status_reg;
    assign out_points_used = out_used_reg;

endmodule

`default_nettype wire

[rtl/fcti_ctrl.sv]
// controller: sequences query walk, divide, set-point search and insert shift
// depends on fcti_pkg
`timescale 1ns / 1ps
`default_nettype none

module fcti_ctrl import fcti_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_Q,
        S_DIV,
        S_SCAN_S,
        S_SHIFT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // next state and commands
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (st.opcode)
                    OP_QUERY:
                    begin
                        if (st.cnt_zero)
                        begin
                            cmd.fan_min = 1'b1;
                            state_next  = S_FINISH;
                        end
                        else
                            state_next = S_SCAN_Q;
                    end
                    OP_SET:
                    begin
                        if (st.t_over)
                        begin
                            cmd.stat_range = 1'b1;
                            state_next     = S_FINISH;
                        end
                        else
                            state_next = S_SCAN_S;
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_FINISH;
                    end
                    default:
                        state_next = S_FINISH;
                endcase
            end
            // find the first point above the query temperature
            S_SCAN_Q:
            begin
                if (st.gt)
                begin
                    if (st.idx_zero)
                    begin
                        cmd.fan_cur = 1'b1;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
                else if (st.last)
                begin
                    cmd.fan_cur = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                    cmd.scan_next = 1'b1;
            end
            S_DIV:
            begin
                if (st.div_done)
                begin
                    cmd.fan_interp = 1'b1;
                    state_next     = S_FINISH;
                end
            end
            // find the first point at or above the new temperature
            S_SCAN_S:
            begin
                if (st.at_end || st.ge)
                begin
                    if (!st.at_end && st.eq)
                    begin
                        cmd.write_speed = 1'b1;
                        state_next      = S_FINISH;
                    end
                    else if (st.full)
                    begin
                        cmd.stat_full = 1'b1;
                        state_next    = S_FINISH;
                    end
                    else
                    begin
                        cmd.shift_start = 1'b1;
                        state_next      = S_SHIFT;
                    end
                end
                else
                    cmd.scan_next = 1'b1;
            end
            // move entries up one slot from the end down to the insert position
            S_SHIFT:
            begin
                if (st.at_pos)
                begin
                    cmd.write_point = 1'b1;
                    state_next      = S_FINISH;
                end
                else
                    cmd.shift_step = 1'b1;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/fan_curve_table_interpolator.sv]
// a clear, an empty-table query or an out-of-range set passes through the idle,
// dispatch and finish states only; a query walks one table entry per cycle (up to
// MAX_POINTS entries) and, when the temperature falls between two entries, waits
// on a 14-bit serial divide; a set walks the table then shifts one entry per cycle.
// one item in flight; the result register lets the next transfer in while a result
// waits. reset loads the six-point default curve and clears min_speed
// top level: joins controller and datapath to the channel interfaces
// depends on fcti_pkg, fcti_if, fcti_ctrl, fcti_dp, fcti_div
`timescale 1ns / 1ps
`default_nettype none

module fan_curve_table_interpolator import fcti_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    fcti_in_if.sink        item,
    fcti_out_if.source     result,
    fcti_cfg_if.sink       cfg
);

    cmd_t  cmd;
    stat_t st;

    // config writes are taken every cycle
    assign cfg.ready = 1'b1;

    fcti_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .st        (st),
        .cmd       (cmd)
    );

    fcti_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .in_opcode       (item.opcode),
        .in_temperature  (item.temperature),
        .in_speed        (item.speed),
        .cfg_we          (cfg.valid),
        .cfg_min_speed   (cfg.min_speed),
        .out_duty_pct    (result.duty_pct),
        .out_status      (result.status),
        .out_points_used (result.points_used)
    );

endmodule

`default_nettype wire

[dv/fan_curve_checker.sv]
// fan curve result checker: watches the item, result and config channels,
// keeps its own copy of the curve table and compares every result transfer
// depends on fcti_pkg and fcti_if
`timescale 1ns / 1ps

module fan_curve_checker import fcti_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    fcti_in_if   item,
    fcti_out_if  result,
    fcti_cfg_if  cfg,
    output int   fail_count,
    output int   results_due
);

    typedef struct packed {
        logic [SPD_W-1:0]  fan;
        logic [STAT_W-1:0] status;
        logic [USED_W-1:0] used;
    } fan_result_t;

    // predicted curve table and register
    logic [PT_W-1:0]  curve_temp [MAX_POINTS];
    logic [PT_W-1:0]  curve_speed[MAX_POINTS];
    int               curve_len;
    logic [SPD_W-1:0] floor_speed;

    fan_result_t      fan_results_q[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // default six-point curve, truncated when the table is smaller
    task automatic load_default_curve();
        int dflt_t[6];
        int dflt_s[6];
        int i;
        dflt_t = '{30, 40, 50, 60, 70, 80};
        dflt_s = '{30, 40, 55, 65, 85, 100};
        curve_len = 0;
        for (i = 0; i < MAX_POINTS; i++)
        begin
            curve_temp[i]  = '0;
            curve_speed[i] = '0;
        end
        for (i = 0; i < 6 && i < MAX_POINTS; i++)
        begin
            curve_temp[i]  = PT_W'(dflt_t[i]);
            curve_speed[i] = PT_W'(dflt_s[i]);
            curve_len      = i + 1;
        end
        floor_speed = '0;
    endtask

    // piecewise linear lookup, division truncating toward zero
    function automatic logic [SPD_W-1:0] lookup_curve_speed(input int t);
        int n, i, lo, hi, dt, ds, off, v;
        n = (curve_len > MAX_POINTS) ? MAX_POINTS : curve_len;
        if (n == 0)
            return (floor_speed > SPEED_CEIL) ? SPEED_CEIL : floor_speed;
        if (t <= int'(curve_temp[0]))
            return curve_speed[0];
        if (t >= int'(curve_temp[n-1]))
            return curve_speed[n-1];
        for (i = 0; i + 1 < n; i++)
        begin
            lo = int'(curve_temp[i]);
            hi = int'(curve_temp[i+1]);
            if (t >= lo && t < hi)
            begin
                dt  = hi - lo;
                ds  = int'(curve_speed[i+1]) - int'(curve_speed[i]);
                off = t - lo;
                if (dt <= 0)
                    return curve_speed[i];
                v = int'(curve_speed[i]) + (off * ds) / dt;
                if (v < 0)
                    v = 0;
                if (v > int'(SPEED_CEIL))
                    v = int'(SPEED_CEIL);
                return SPD_W'(v);
            end
        end
        return curve_speed[n-1];
    endfunction

    // update an existing point or insert a new one in temperature order
    function automatic logic [STAT_W-1:0] apply_set_point(input int t, input int s);
        int n, pos, i;
        if (t > int'(TEMP_CEIL))
            return ST_RANGE;
        if (s > int'(SPEED_CEIL))
            s = int'(SPEED_CEIL);
        n   = (curve_len > MAX_POINTS) ? MAX_POINTS : curve_len;
        pos = n;
        for (i = 0; i < n; i++)
        begin
            if (int'(curve_temp[i]) >= t)
            begin
                pos = i;
                break;
            end
        end
        if (pos < n && int'(curve_temp[pos]) == t)
        begin
            curve_speed[pos] = PT_W'(s);
            return ST_OK;
        end
        if (n >= MAX_POINTS)
            return ST_FULL;
        for (i = n; i > pos; i--)
        begin
            curve_temp[i]  = curve_temp[i-1];
            curve_speed[i] = curve_speed[i-1];
        end
        curve_temp[pos]  = PT_W'(t);
        curve_speed[pos] = PT_W'(s);
        curve_len        = n + 1;
        return ST_OK;
    endfunction

    function automatic fan_result_t predict_fan_result(input logic [OPC_W-1:0] op,
                                                       input logic [TEMP_W-1:0] t,
                                                       input logic [SPD_W-1:0] s);
        fan_result_t r;
        r = '0;
        case (op)
            OP_QUERY: r.fan    = lookup_curve_speed(int'(t));
            OP_SET:   r.status = apply_set_point(int'(t), int'(s));
            OP_CLEAR: curve_len = 0;
            default:  ;
        endcase
        r.used = USED_W'(curve_len);
        return r;
    endfunction

    initial
    begin
        fail_count  = 0;
        results_due = 0;
        load_default_curve();
    end

    // sample all channels at the rising edge
    always @(posedge clk)
    begin
        fan_result_t got, want;
        if (!rst_n)
        begin
            load_default_curve();
            fan_results_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                floor_speed = cfg.min_speed;
            // result transfer against the oldest prediction
            if (result.valid && result.ready)
            begin
                got.fan    = result.duty_pct;
                got.status = result.status;
                got.used   = result.points_used;
                if (fan_results_q.size() == 0)
                    report_mismatch("result with none outstanding", got.fan, -1);
                else
                begin
                    want = fan_results_q.pop_front();
                    if (got.fan !== want.fan)
                        report_mismatch("duty_pct", got.fan, want.fan);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.used !== want.used)
                        report_mismatch("points_used", got.used, want.used);
                end
            end
            // item transfer
            if (item.valid && item.ready)
                fan_results_q.push_back(predict_fan_result(item.opcode, item.temperature,
                                                           item.speed));
        end
        results_due = fan_results_q.size();
    end

endmodule

[dv/tb.sv]
// testbench top for the fan curve table interpolator: clock, reset, item and
// config stimulus, result back-pressure and the final verdict
// depends on fcti_pkg, fcti_if, fan_curve_checker and the block itself
`timescale 1ns / 1ps

module tb;
    import fcti_pkg::*;

    localparam logic [OPC_W-1:0] OP_NONE = 2'd3;
    localparam int IDLE_PCT   = 27;
    localparam int DRAIN_WAIT = 40;
    localparam int HOLD_LEN   = 300;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 135;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   results_due;
    bit   steady;
    int   hold_asks;

    fcti_in_if  item_ch();
    fcti_out_if result_ch();
    fcti_cfg_if cfg_ch();

    fan_curve_table_interpolator uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    fan_curve_checker curve_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // result receiver: random stalls plus a long hold-off on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // one item transfer, entered and left at a falling edge
    task automatic push_item(input logic [OPC_W-1:0] op, input int t, input int s);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                item_ch.valid <= 1'b0;
                @(negedge clk);
            end
        end
        item_ch.valid       <= 1'b1;
        item_ch.opcode      <= op;
        item_ch.temperature <= TEMP_W'(t);
        item_ch.speed       <= SPD_W'(s);
        do
            @(posedge clk);
        while (!(item_ch.valid && item_ch.ready));
        @(negedge clk);
    endtask

    // stop offering and wait until every predicted result has arrived
    task automatic wait_drain();
        item_ch.valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_min_speed(input int v);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.min_speed <= SPD_W'(v);
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // random item, mostly queries and set-points inside the valid range
    task automatic push_random_item(input int clear_pct);
        int pick;
        int t;
        int s;
        pick = $urandom_range(0, 99);
        t    = $urandom_range(0, 255);
        s    = $urandom_range(0, 127);
        if (pick < 46)
        begin
            if ($urandom_range(0, 9) != 0)
                t = $urandom_range(0, 105);
            push_item(OP_QUERY, t, s);
        end
        else if (pick < 98 - clear_pct)
        begin
            if ($urandom_range(0, 9) != 0)
                t = $urandom_range(0, 100);
            if ($urandom_range(0, 9) != 0)
                s = $urandom_range(0, 100);
            push_item(OP_SET, t, s);
        end
        else if (pick < 98)
            push_item(OP_CLEAR, t, s);
        else
            push_item(OP_NONE, t, s);
    endtask

    initial
    begin
        int ph;
        int k;
        int v;
        rst_n               = 1'b0;
        steady              = 1'b0;
        hold_asks           = 0;
        item_ch.valid       = 1'b0;
        item_ch.opcode      = OP_QUERY;
        item_ch.temperature = '0;
        item_ch.speed       = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.min_speed    = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_min_speed(0);

        // default curve: clamps at both ends, interpolation, updates and inserts
        push_item(OP_QUERY, 0, 0);
        push_item(OP_QUERY, 30, 0);
        push_item(OP_QUERY, 45, 0);
        push_item(OP_QUERY, 79, 0);
        push_item(OP_QUERY, 80, 0);
        push_item(OP_QUERY, 255, 127);
        push_item(OP_SET, 50, 60);
        push_item(OP_SET, 35, 127);
        push_item(OP_SET, 101, 5);
        push_item(OP_SET, 255, 127);
        push_item(OP_SET, 0, 0);
        push_item(OP_SET, 100, 100);
        push_item(OP_QUERY, 37, 0);
        push_item(OP_NONE, 255, 127);
        push_item(OP_CLEAR, 0, 0);
        push_item(OP_QUERY, 0, 0);
        wait_drain();

        // empty table with min_speed above the ceiling, falling slope
        write_min_speed(127);
        push_item(OP_QUERY, 255, 0);
        push_item(OP_SET, 60, 20);
        push_item(OP_QUERY, 59, 0);
        push_item(OP_QUERY, 61, 0);
        push_item(OP_SET, 40, 100);
        push_item(OP_QUERY, 47, 0);
        push_item(OP_QUERY, 45, 0);
        push_item(OP_CLEAR, 0, 0);
        push_item(OP_QUERY, 10, 0);

        // random phases, each starting from an idle block with a new min_speed
        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_drain();
            case (ph)
                0:       v = 100;
                1:       v = 0;
                2:       v = 127;
                default: v = $urandom_range(0, 127);
            endcase
            write_min_speed(v);
            steady = (ph == 3);
            if (ph == 5)
                hold_asks++;
            for (k = 0; k < PHASE_LEN; k++)
            begin
                push_random_item((ph == 6) ? 0 : 2);
                // mid-phase pause until everything is back
                if (ph == 4 && k == PHASE_LEN / 2)
                    wait_drain();
            end
        end
        steady = 1'b0;
        wait_drain();

        if (fail_count == 0 && results_due == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
rtl/fcti_pkg.sv
rtl/fcti_if.sv
rtl/fcti_div.sv
rtl/fcti_dp.sv
rtl/fcti_ctrl.sv
rtl/fan_curve_table_interpolator.sv
dv/fan_curve_checker.sv
dv/tb.sv
